/* sv/sfs_pkg.sv */
// Shared types and constants for the sprite frame sequencer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package sfs_pkg;

  // Table geometry
  localparam int MAX_FRAMES = 256;
  localparam int DELAY_BITS = 16;
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int CNT_W      = FRAME_W + 1;
  localparam int ARITH_W    = CNT_W + 2;

  // Counters and register widths
  localparam int TICK_W   = 32;
  localparam int BITCNT_W = $clog2(TICK_W);
  localparam int ELAPSE_W = 24;
  localparam int LOOPS_W  = 16;
  localparam int MODE_W   = 4;
  localparam int STEP_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W    = 24;

  // Stream word widths
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;
  localparam int KIND_W     = 2;

  // Mode bits
  localparam int MODE_REVERSE = 0;
  localparam int MODE_PINGPONG = 1;
  localparam int MODE_STOP    = 2;
  localparam int MODE_SUBLOOP = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK    = 2'd0,
    KIND_DELAY   = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_PAUSE   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_COUNT = 3'd0,
    REG_MODE        = 3'd1,
    REG_STEP        = 3'd2,
    REG_LOOP_START  = 3'd3,
    REG_LOOP_END    = 3'd4,
    REG_ITER_LIMIT  = 3'd5,
    REG_TIME_LIMIT  = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_STEP,
    ST_RESP
  } st_t;

  // Status of the serial remainder unit
  typedef struct packed {
    logic done;
    logic zero;
  } rem_stat_t;

  // Outcome of one frame step
  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               moving_down;
    logic [LOOPS_W-1:0] loops;
    logic               stop;
    logic               hold;
  } step_res_t;

  // Frame count clamped to 1..MAX_FRAMES
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] fc);
    logic [CNT_W-1:0] r;
    begin
      r = fc;
      if (fc == '0) r = CNT_W'(1);
      else if (fc > CNT_W'(MAX_FRAMES)) r = CNT_W'(MAX_FRAMES);
      return r;
    end
  endfunction

endpackage

/* sv/sfs_delay_ram.sv */
// Per-frame delay store: one write port, one registered read port.
// Depends on sfs_pkg.
`timescale 1ns / 1ps

module sfs_delay_ram (
  input  logic                           clk,
  input  logic                           we,
  input  logic [sfs_pkg::FRAME_W-1:0]    waddr,
  input  logic [sfs_pkg::DELAY_BITS-1:0] wdata,
  input  logic [sfs_pkg::FRAME_W-1:0]    raddr,
  output logic [sfs_pkg::DELAY_BITS-1:0] rdata
);
  import sfs_pkg::*;

  logic [DELAY_BITS-1:0] mem [MAX_FRAMES];
  logic [DELAY_BITS-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/sfs_rem_serial.sv */
// Bit-serial restoring remainder: tick counter mod frame delay, one bit a cycle.
// Depends on sfs_pkg.
`timescale 1ns / 1ps

module sfs_rem_serial (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [sfs_pkg::TICK_W-1:0]     dividend,
  input  logic [sfs_pkg::DELAY_BITS-1:0] divisor,
  output sfs_pkg::rem_stat_t             stat
);
  import sfs_pkg::*;

  logic [TICK_W-1:0]     shift_r, shift_nxt;
  logic [DELAY_BITS-1:0] rem_r, rem_nxt;
  logic [DELAY_BITS-1:0] div_r, div_nxt;
  logic [BITCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DELAY_BITS:0]   trial;

  // one restoring step per cycle, MSB of the dividend first
  always_comb begin
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    trial     = {rem_r, shift_r[TICK_W-1]};
    if (start) begin
      shift_nxt = dividend;
      rem_nxt   = '0;
      div_nxt   = divisor;
      cnt_nxt   = BITCNT_W'(TICK_W - 1);
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      shift_nxt = {shift_r[TICK_W-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = DELAY_BITS'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[DELAY_BITS-1:0];
      end
      cnt_nxt = cnt_r - BITCNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    rem_r   <= rem_nxt;
    div_r   <= div_nxt;
  end

  assign stat.done = done_r;
  assign stat.zero = (rem_r == '0);

endmodule

/* sv/sfs_step.sv */
// Frame step: wrap, reverse, ping-pong bounce and subsection range selection.
// Depends on sfs_pkg.
`timescale 1ns / 1ps

module sfs_step (
  input  logic [sfs_pkg::FRAME_W-1:0] cur,
  input  logic [sfs_pkg::CNT_W-1:0]   fc,
  input  logic [sfs_pkg::MODE_W-1:0]  mode,
  input  logic [sfs_pkg::STEP_W-1:0]  step_amount,
  input  logic [sfs_pkg::FRAME_W-1:0] loop_start,
  input  logic [sfs_pkg::CNT_W-1:0]   loop_end,
  input  logic [sfs_pkg::LOOPS_W-1:0] loops,
  input  logic [sfs_pkg::LOOPS_W-1:0] iter_limit,
  input  logic                        moving_down,
  output sfs_pkg::step_res_t          res
);
  import sfs_pkg::*;

  localparam logic signed [ARITH_W-1:0] ONE_S = ARITH_W'(1);
  localparam logic signed [ARITH_W-1:0] TWO_S = ARITH_W'(2);

  logic [CNT_W-1:0]   le_c;
  logic               pp, stop_bit, sub, in_sub, wrap, limit_hit;
  logic [LOOPS_W-1:0] loops_inc;
  logic signed [ARITH_W-1:0] cur_s, stp_s, ls_s, le_s, start_s, end_s;
  logic signed [ARITH_W-1:0] up_s, dn_s, f_s, top_s, bot_s;

  // active range
  always_comb begin
    pp       = mode[MODE_PINGPONG];
    stop_bit = mode[MODE_STOP];
    le_c     = (loop_end > fc) ? fc : loop_end;
    sub      = mode[MODE_SUBLOOP] && ({1'b0, loop_start} < le_c);
    in_sub   = sub && ((!pp && loops >= LOOPS_W'(1)) || (pp && loops >= LOOPS_W'(2)));
    cur_s    = $signed({{(ARITH_W-FRAME_W){1'b0}}, cur});
    stp_s    = $signed({{(ARITH_W-STEP_W){1'b0}}, step_amount});
    ls_s     = $signed({{(ARITH_W-FRAME_W){1'b0}}, loop_start});
    le_s     = $signed({{(ARITH_W-CNT_W){1'b0}}, le_c});
    start_s  = in_sub ? ls_s : '0;
    end_s    = in_sub ? le_s : $signed({{(ARITH_W-CNT_W){1'b0}}, fc});
    up_s     = cur_s + stp_s;
    dn_s     = cur_s - stp_s;
    top_s    = end_s - TWO_S;
    bot_s    = start_s + ONE_S;
  end

  // loop count and limit after a completed pass
  always_comb begin
    loops_inc = (loops != '1) ? loops + LOOPS_W'(1) : loops;
    limit_hit = (iter_limit != '0) && (loops_inc >= iter_limit);
  end

  // next frame
  always_comb begin
    f_s             = cur_s;
    wrap            = 1'b0;
    res.stop        = 1'b0;
    res.moving_down = moving_down;
    if (!pp) begin
      if (!mode[MODE_REVERSE]) begin
        f_s = up_s;
        if (up_s >= end_s) begin
          f_s      = sub ? ls_s : start_s;
          wrap     = 1'b1;
          res.stop = stop_bit || limit_hit;
        end
      end else begin
        f_s = dn_s;
        if (dn_s <= start_s) begin
          f_s      = sub ? (le_s - ONE_S) : (end_s - ONE_S);
          wrap     = 1'b1;
          res.stop = stop_bit || limit_hit;
        end
      end
    end else if (!moving_down) begin
      f_s = up_s;
      if (up_s >= end_s) begin
        wrap            = 1'b1;
        f_s             = (top_s < start_s) ? start_s : top_s;
        res.moving_down = 1'b1;
        res.stop        = limit_hit;
      end
    end else begin
      f_s = dn_s;
      if (dn_s < start_s) begin
        wrap            = 1'b1;
        res.moving_down = 1'b0;
        if (stop_bit || limit_hit) begin
          f_s      = start_s;
          res.stop = 1'b1;
        end else begin
          f_s = (bot_s >= end_s) ? start_s : bot_s;
        end
      end
    end
    res.frame = f_s[FRAME_W-1:0];
    res.loops = wrap ? loops_inc : loops;
    // a finished run past the limit no longer steps
    res.hold  = (iter_limit != '0) && (loops > iter_limit);
  end

endmodule

/* sv/sprite_frame_sequencer.sv */
// Sprite animation frame sequencer, top level.
// Depends on sfs_pkg, sfs_delay_ram, sfs_rem_serial, sfs_step.
//
// Use: each input word carries a kind in in_tuser: tick, delay write,
// restart or pause. Every accepted word yields exactly one result word
// with the current frame, a frame-changed flag, the loop count and the
// paused and done flags. Configuration registers are to be written by
// the user through cfg_we / cfg_index / cfg_wdata only while the block
// is idle; the block itself does not enforce this. Sequence: a tick
// that runs the animation goes from accept through the LOAD state, which
// loads the remainder unit with the frame delay, the bit-serial remainder
// unit (tick counter mod delay, one dividend bit per cycle) with its
// registered done flag, the STEP state, which steps the frame, and the
// RESP state, which loads the result. Other words, and ticks while
// paused or done or that hit the time limit, go straight to RESP. A new
// word is accepted only after the previous one is finished.
// Reset (rst_n low, synchronous) loads the register defaults, paused set,
// frame 0, counters cleared; the delay table is not cleared and must be
// written before restart. When out_tready is low the result word holds in
// the output register; the next word is still accepted and processed, and
// its result waits until the register frees.
`timescale 1ns / 1ps

module sprite_frame_sequencer (
  input  logic                                clk,
  input  logic                                rst_n,
  // fields from bit 0: frame_index[7:0], delay_value[23:8], pause_flag[24]
  input  logic [sfs_pkg::IN_DATA_W-1:0]       in_tdata,
  // fields from bit 0: kind[1:0]
  input  logic [sfs_pkg::KIND_W-1:0]          in_tuser,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // fields from bit 0: frame[7:0], frame_changed[8], loop_total[24:9],
  // is_paused[25], is_done[26]
  output logic [sfs_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_we,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sfs_pkg::CFG_W-1:0]           cfg_wdata
);
  import sfs_pkg::*;

  // configuration registers
  logic [CNT_W-1:0]    frame_count_r;
  logic [MODE_W-1:0]   mode_r;
  logic [STEP_W-1:0]   step_r;
  logic [FRAME_W-1:0]  loop_start_r;
  logic [CNT_W-1:0]    loop_end_r;
  logic [LOOPS_W-1:0]  iter_limit_r;
  logic [ELAPSE_W-1:0] time_limit_r;

  // animation state
  logic [TICK_W-1:0]   tick_cnt_r, tick_cnt_nxt;
  logic [ELAPSE_W-1:0] elapsed_r, elapsed_nxt, el_inc;
  logic [FRAME_W-1:0]  frame_r, frame_nxt;
  logic [LOOPS_W-1:0]  loops_r, loops_nxt;
  logic                paused_r, paused_nxt;
  logic                finished_r, finished_nxt;
  logic                md_r, md_nxt;
  logic                changed_r, changed_nxt;

  // control
  st_t                 st_r, st_nxt;
  logic                in_acc, div_start, step_en, resp_en;
  logic                el_run, tl_hit, tick_active;
  logic                out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  kind_t               kind;
  logic [FRAME_W-1:0]  w_index;
  logic [DELAY_BITS-1:0] w_delay;
  logic                w_pause;
  logic [CNT_W-1:0]    fc;
  logic [DELAY_BITS-1:0] rd_delay, divisor;
  rem_stat_t           rem_stat;
  step_res_t           step_res;

  assign kind    = kind_t'(in_tuser);
  assign w_index = in_tdata[FRAME_W-1:0];
  assign w_delay = in_tdata[FRAME_W +: DELAY_BITS];
  assign w_pause = in_tdata[FRAME_W + DELAY_BITS];
  assign fc      = eff_count(frame_count_r);
  assign in_acc  = in_tvalid && in_tready;
  assign divisor = (rd_delay == '0) ? DELAY_BITS'(1) : rd_delay;

  // time limit bookkeeping for a tick
  always_comb begin
    el_run      = (time_limit_r != '0) && !paused_r && !finished_r;
    el_inc      = (elapsed_r != '1) ? elapsed_r + ELAPSE_W'(1) : elapsed_r;
    tl_hit      = el_run && (el_inc >= time_limit_r);
    tick_active = !paused_r && !finished_r && !tl_hit;
  end

  sfs_delay_ram u_ram (
    .clk   (clk),
    .we    (in_acc && (kind == KIND_DELAY)),
    .waddr (w_index),
    .wdata (w_delay),
    .raddr (frame_r),
    .rdata (rd_delay)
  );

  sfs_rem_serial u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (tick_cnt_r),
    .divisor  (divisor),
    .stat     (rem_stat)
  );

  sfs_step u_step (
    .cur         (frame_r),
    .fc          (fc),
    .mode        (mode_r),
    .step_amount (step_r),
    .loop_start  (loop_start_r),
    .loop_end    (loop_end_r),
    .loops       (loops_r),
    .iter_limit  (iter_limit_r),
    .moving_down (md_r),
    .res         (step_res)
  );

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          st_nxt = ((kind == KIND_TICK) && tick_active) ? ST_LOAD : ST_RESP;
        end
      end
      ST_LOAD: st_nxt = ST_DIV;
      ST_DIV:  if (rem_stat.done) st_nxt = ST_STEP;
      ST_STEP: st_nxt = ST_RESP;
      ST_RESP: if (!out_valid_r || out_tready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = (st_r == ST_IDLE);
    div_start = (st_r == ST_LOAD);
    step_en   = (st_r == ST_STEP);
    resp_en   = (st_r == ST_RESP) && (!out_valid_r || out_tready);
  end

  // animation state update
  always_comb begin
    tick_cnt_nxt = tick_cnt_r;
    elapsed_nxt  = elapsed_r;
    frame_nxt    = frame_r;
    loops_nxt    = loops_r;
    paused_nxt   = paused_r;
    finished_nxt = finished_r;
    md_nxt       = md_r;
    changed_nxt  = changed_r;
    if (in_acc) begin
      changed_nxt = 1'b0;
      unique case (kind)
        KIND_TICK: begin
          tick_cnt_nxt = tick_cnt_r + TICK_W'(1);
          if (el_run) begin
            elapsed_nxt = el_inc;
          end
          if (tl_hit) begin
            paused_nxt   = 1'b1;
            finished_nxt = 1'b1;
          end
        end
        KIND_DELAY: begin
          // table write only
        end
        KIND_RESTART: begin
          paused_nxt   = 1'b0;
          finished_nxt = 1'b0;
          loops_nxt    = '0;
          elapsed_nxt  = '0;
          frame_nxt    = mode_r[MODE_REVERSE] ? FRAME_W'(fc - CNT_W'(1)) : '0;
        end
        KIND_PAUSE: paused_nxt = w_pause;
        default: ;
      endcase
    end else if (step_en && rem_stat.zero && !step_res.hold) begin
      changed_nxt = (fc > CNT_W'(1));
      frame_nxt   = step_res.frame;
      md_nxt      = step_res.moving_down;
      loops_nxt   = step_res.loops;
      if (step_res.stop) begin
        paused_nxt   = 1'b1;
        finished_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      tick_cnt_r <= '0;
      elapsed_r  <= '0;
      frame_r    <= '0;
      loops_r    <= '0;
      paused_r   <= 1'b1;
      finished_r <= 1'b0;
      md_r       <= 1'b1;
      changed_r  <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      tick_cnt_r <= tick_cnt_nxt;
      elapsed_r  <= elapsed_nxt;
      frame_r    <= frame_nxt;
      loops_r    <= loops_nxt;
      paused_r   <= paused_nxt;
      finished_r <= finished_nxt;
      md_r       <= md_nxt;
      changed_r  <= changed_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= CNT_W'(1);
      mode_r        <= '0;
      step_r        <= STEP_W'(1);
      loop_start_r  <= '0;
      loop_end_r    <= '0;
      iter_limit_r  <= '0;
      time_limit_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_FRAME_COUNT: frame_count_r <= cfg_wdata[CNT_W-1:0];
        REG_MODE:        mode_r        <= cfg_wdata[MODE_W-1:0];
        REG_STEP:        step_r        <= cfg_wdata[STEP_W-1:0];
        REG_LOOP_START:  loop_start_r  <= cfg_wdata[FRAME_W-1:0];
        REG_LOOP_END:    loop_end_r    <= cfg_wdata[CNT_W-1:0];
        REG_ITER_LIMIT:  iter_limit_r  <= cfg_wdata[LOOPS_W-1:0];
        REG_TIME_LIMIT:  time_limit_r  <= cfg_wdata[ELAPSE_W-1:0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resp_en) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_en) begin
      out_data_r <= {{(OUT_DATA_W - FRAME_W - LOOPS_W - 3){1'b0}},
                     finished_r, paused_r, loops_r, changed_r, frame_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* sv/sfs_checker.sv */
// Port-level checks for the sprite frame sequencer, bound to the top level.
// Depends on sfs_pkg and sprite_frame_sequencer.
`timescale 1ns / 1ps

module sfs_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [sfs_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tvalid,
  input logic                           out_tready
);
  import sfs_pkg::*;

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // a stalled result word keeps its bits
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result word changed while stalled");

  // one word in flight: no accept right after an accept
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word accepted while busy");

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
